// ----- hdl/nfir_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package nfir_pkg;
    localparam int MaxTaps = 7;
    localparam int SampleBits = 16;
    localparam int HistDepth = MaxTaps - 1;
    localparam int CoefBits = 16;
    localparam int NumRegs = MaxTaps + 1;
    localparam int IdxBits = 3;
    localparam int RegIdxBits = 4;
    localparam int TapBits = 3;
    localparam int AccBits = SampleBits + CoefBits + 3;
    localparam int SumBits = CoefBits + 3;
    localparam int CntBits = 3;

    localparam logic [RegIdxBits-1:0] RegTapCount = 4'd0;

    typedef logic signed [SampleBits-1:0] sample_t;
    typedef logic signed [CoefBits-1:0] coef_t;

    // One queued job: either a plain sample to emit or a filter request.
    typedef struct packed {
        logic            filt;
        logic            last;
        sample_t         value;
        logic [IdxBits-1:0] p;
        sample_t [MaxTaps-1:0] win;
    } job_t;

    function automatic sample_t sat(input logic signed [AccBits:0] v);
        logic signed [AccBits:0] hi;
        logic signed [AccBits:0] lo;
        hi = (AccBits+1)'((1 <<< (SampleBits-1)) - 1);
        lo = -hi - 1;
        if (v > hi) return sample_t'(hi);
        if (v < lo) return sample_t'(lo);
        return sample_t'(v);
    endfunction
endpackage
`default_nettype wire

// ----- hdl/nfir_front.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nfir_front (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_ready,
    input  wire nfir_pkg::sample_t in_sample,
    input  wire logic in_last,
    input  wire logic [nfir_pkg::TapBits-1:0] tap_count,
    output logic job_valid,
    output nfir_pkg::job_t job,
    input  wire logic job_ready
);
    import nfir_pkg::*;

    // One accepted sample expands to up to four jobs, produced one per cycle while the queue accepts them.
    logic [TapBits-1:0] pos_reg, pos_next;
    sample_t [HistDepth-1:0] hist_reg, hist_next;
    logic busy_reg, busy_next;
    sample_t cur_reg, cur_next;
    logic last_reg, last_next;
    logic [IdxBits-1:0] p_reg, p_next;
    logic [CntBits-1:0] k_reg, k_next;
    logic main_reg, main_next;
    logic [CntBits-1:0] fl_reg, fl_next;

    logic [IdxBits-1:0] p_now;
    logic [CntBits-1:0] r;
    logic [CntBits-1:0] d;
    sample_t [MaxTaps-1:0] win;

    always_comb
    begin
        logic [TapBits-1:0] t;
        t = tap_count;
        if (t == '0) t = TapBits'(1);
        p_now = IdxBits'((t - TapBits'(1)) >> 1);
    end

    assign in_ready = !busy_reg;

    always_comb
    begin
        for (int m = 0; m < MaxTaps; m++) begin
            win[m] = '0;
            if (m < 2 * int'(p_reg)) win[m] = hist_reg[2 * int'(p_reg) - m - 1];
            else if (m == 2 * int'(p_reg)) win[m] = cur_reg;
        end
    end

    assign d = fl_reg - CntBits'(1);

    always_comb
    begin
        job = '0;
        job.p = p_reg;
        job.win = win;
        job_valid = 1'b0;
        if (busy_reg) begin
            job_valid = 1'b1;
            if (main_reg) begin
                job.filt = (k_reg >= CntBits'(2 * p_reg));
                job.value = (p_reg == '0) ? cur_reg : hist_reg[p_reg - IdxBits'(1)];
                job.last = last_reg && (fl_reg == '0);
            end else begin
                job.value = (d == '0) ? cur_reg : hist_reg[d - CntBits'(1)];
                job.last = (fl_reg == CntBits'(1));
            end
        end
    end

    always_comb
    begin
        pos_next = pos_reg; hist_next = hist_reg; busy_next = busy_reg;
        cur_next = cur_reg; last_next = last_reg; p_next = p_reg; k_next = k_reg;
        main_next = main_reg; fl_next = fl_reg;
        r = (pos_reg >= CntBits'(p_now)) ? CntBits'(p_now) : pos_reg + CntBits'(1);
        if (in_valid && in_ready) begin
            cur_next = in_sample; last_next = in_last; p_next = p_now; k_next = pos_reg;
            main_next = (pos_reg >= CntBits'(p_now));
            fl_next = in_last ? r : '0;
            busy_next = main_next || (fl_next != '0);
            // A sample that releases no job still enters the history.
            if (!busy_next) begin
                for (int j = HistDepth - 1; j > 0; j--) hist_next[j] = hist_reg[j-1];
                hist_next[0] = in_sample;
            end
            if (in_last) pos_next = '0;
            else if (pos_reg < TapBits'(HistDepth)) pos_next = pos_reg + TapBits'(1);
        end else if (busy_reg && job_ready) begin
            if (main_reg) main_next = 1'b0;
            else fl_next = fl_reg - CntBits'(1);
            if ((main_reg && fl_reg == '0) || (!main_reg && fl_reg == CntBits'(1))) begin
                busy_next = 1'b0;
                for (int j = HistDepth - 1; j > 0; j--) hist_next[j] = hist_reg[j-1];
                hist_next[0] = cur_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0; hist_reg <= '0; busy_reg <= 1'b0; main_reg <= 1'b0; fl_reg <= '0;
        end else begin
            pos_reg <= pos_next; hist_reg <= hist_next; busy_reg <= busy_next;
            main_reg <= main_next; fl_reg <= fl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next; last_reg <= last_next; p_reg <= p_next; k_reg <= k_next;
    end
endmodule
`default_nettype wire

// ----- hdl/nfir_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nfir_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_valid,
    output logic wr_ready,
    input  wire nfir_pkg::job_t wr_data,
    output logic rd_valid,
    input  wire logic rd_ready,
    output nfir_pkg::job_t rd_data
);
    import nfir_pkg::*;

    // Two-entry queue.
    job_t mem_reg [2];
    logic wp_reg, rp_reg;
    logic [1:0] cnt_reg;
    logic wr, rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rp_reg];
    assign wr = wr_valid && wr_ready;
    assign rd = rd_valid && rd_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= 1'b0; rp_reg <= 1'b0; cnt_reg <= '0;
        end else begin
            if (wr) wp_reg <= !wp_reg;
            if (rd) rp_reg <= !rp_reg;
            cnt_reg <= cnt_reg + 2'(wr) - 2'(rd);
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr) mem_reg[wp_reg] <= wr_data;
    end
endmodule
`default_nettype wire

// ----- hdl/nfir_back.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nfir_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic job_valid,
    output logic job_ready,
    input  wire nfir_pkg::job_t job,
    input  wire nfir_pkg::coef_t [nfir_pkg::MaxTaps-1:0] coefs,
    output logic out_valid,
    input  wire logic out_ready,
    output nfir_pkg::sample_t out_value,
    output logic out_last
);
    import nfir_pkg::*;

    localparam int NumBits = AccBits + 1;
    localparam int DivSteps = NumBits;

    typedef enum logic [2:0] {S_IDLE, S_MAC, S_PREP, S_DIV, S_FIN, S_OUT} state_t;
    state_t state_reg;
    job_t job_reg;
    logic [IdxBits-1:0] m_reg;
    logic signed [SampleBits+CoefBits-1:0] prod_reg;
    logic prod_v_reg;
    logic signed [AccBits-1:0] acc_reg;
    logic signed [SumBits-1:0] sum_reg;
    logic [NumBits-1:0] num_reg;
    logic [SumBits:0] den_reg;
    logic [NumBits:0] rem_reg;
    logic [NumBits-1:0] q_reg;
    logic [$clog2(DivSteps+1)-1:0] cnt_reg;
    logic neg_reg;
    sample_t val_reg;
    logic last_reg;

    assign job_ready = (state_reg == S_IDLE);
    assign out_valid = (state_reg == S_OUT);
    assign out_value = val_reg;
    assign out_last = last_reg;

    logic [NumBits:0] rem_sh;
    assign rem_sh = {rem_reg[NumBits-1:0], num_reg[NumBits-1]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
        end else begin
            case (state_reg)
                S_IDLE:
                begin
                    if (job_valid) begin
                        job_reg <= job;
                        last_reg <= job.last;
                        if (job.filt) begin
                            acc_reg <= '0; sum_reg <= '0; m_reg <= '0; prod_v_reg <= 1'b0;
                            state_reg <= S_MAC;
                        end else begin
                            val_reg <= job.value;
                            state_reg <= S_OUT;
                        end
                    end
                end
                S_MAC:
                begin
                    // One multiply per cycle, registered before accumulation.
                    if (prod_v_reg) acc_reg <= acc_reg + AccBits'(prod_reg);
                    if (m_reg <= 2 * job_reg.p) begin
                        prod_reg <= job_reg.win[m_reg] * coefs[m_reg];
                        sum_reg <= sum_reg + SumBits'(coefs[m_reg]);
                        prod_v_reg <= 1'b1;
                        m_reg <= m_reg + IdxBits'(1);
                    end else begin
                        prod_v_reg <= 1'b0;
                        if (!prod_v_reg) state_reg <= S_PREP;
                    end
                end
                S_PREP:
                begin
                    if (sum_reg == '0) begin
                        val_reg <= sat((AccBits+1)'(acc_reg >>> 14));
                        state_reg <= S_OUT;
                    end else begin
                        neg_reg <= (acc_reg < 0) != (sum_reg < 0);
                        // Numerator 2|acc|+|sum|, divisor 2|sum|.
                        num_reg <= NumBits'((acc_reg < 0) ? -acc_reg : acc_reg) * 2
                            + NumBits'((sum_reg < 0) ? -sum_reg : sum_reg);
                        den_reg <= (SumBits+1)'((sum_reg < 0) ? -sum_reg : sum_reg) << 1;
                        rem_reg <= '0; q_reg <= '0; cnt_reg <= '0;
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    num_reg <= num_reg << 1;
                    if (rem_sh >= (NumBits+1)'(den_reg)) begin
                        rem_reg <= rem_sh - (NumBits+1)'(den_reg);
                        q_reg <= {q_reg[NumBits-2:0], 1'b1};
                    end else begin
                        rem_reg <= rem_sh;
                        q_reg <= {q_reg[NumBits-2:0], 1'b0};
                    end
                    cnt_reg <= cnt_reg + ($clog2(DivSteps+1))'(1);
                    if (cnt_reg == ($clog2(DivSteps+1))'(DivSteps - 1)) state_reg <= S_FIN;
                end
                S_FIN:
                begin
                    val_reg <= sat(neg_reg ? -$signed({1'b0, q_reg[NumBits-2:0]})
                                           : $signed({1'b0, q_reg[NumBits-2:0]}));
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready) state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

// ----- hdl/normalized_fir_edge_passthrough_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Normalized odd-length FIR with edge pass-through.
// Input stream s_axis: tdata = sample (16 bits, signed), tlast = end of series.
// Output stream m_axis: tdata = value (16 bits), tlast = last result of series.
// Configuration: cfg_we, cfg_addr (0 tap count, 1..7 coef_0..coef_6), cfg_wdata.
// Each accepted sample yields up to four beats, emitted in series order; the
// output lags the input by half a window. The first and last half-window samples pass
// unchanged; inner samples are weighted and divided by the weight sum, or scaled down by 2^14 if it is zero.
// A passed sample is registered in the front part, the queue and the back part.
// A filtered one goes through multiply-accumulate (one multiplier, one tap per
// cycle), a set-up step, a radix-2 divider and a final step that applies the sign
// and saturates. The back part takes no new job until its beat has been taken.
// The front part expands samples into jobs, a two-entry queue decouples it
// from the arithmetic back part, and a stall on m_axis backs up through both.
// Reset clears history, position and queue and loads tap count 3 with
// weights 1.0, 1.0, 1.0 and zeros.
module normalized_fir_edge_passthrough_top (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic s_axis_tvalid,
    output logic s_axis_tready,
    input  wire logic [15:0] s_axis_tdata, // [15:0] sample
    input  wire logic s_axis_tlast,
    output logic m_axis_tvalid,
    input  wire logic m_axis_tready,
    output logic [15:0] m_axis_tdata, // [15:0] value
    output logic m_axis_tlast,
    input  wire logic cfg_we,
    input  wire logic [nfir_pkg::RegIdxBits-1:0] cfg_addr,
    input  wire logic [15:0] cfg_wdata
);
    import nfir_pkg::*;

    logic [TapBits-1:0] tap_reg;
    coef_t [MaxTaps-1:0] coef_reg;
    logic fj_valid, fj_ready, bj_valid, bj_ready;
    job_t fj, bj;
    sample_t val;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            tap_reg <= TapBits'(3);
            coef_reg <= {{4{16'h0000}}, {3{16'h4000}}};
        end else if (cfg_we) begin
            if (cfg_addr == RegTapCount) tap_reg <= cfg_wdata[TapBits-1:0];
            else if (cfg_addr < RegIdxBits'(NumRegs))
                coef_reg[IdxBits'(cfg_addr - RegIdxBits'(1))] <= cfg_wdata;
        end
    end

    nfir_front u_front (
        .clk, .rst_n,
        .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
        .in_sample(s_axis_tdata), .in_last(s_axis_tlast),
        .tap_count(tap_reg),
        .job_valid(fj_valid), .job(fj), .job_ready(fj_ready)
    );

    nfir_queue u_queue (
        .clk, .rst_n,
        .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
        .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
    );

    nfir_back u_back (
        .clk, .rst_n,
        .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
        .coefs(coef_reg),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_value(val), .out_last(m_axis_tlast)
    );

    assign m_axis_tdata = val;
endmodule
`default_nettype wire

// ----- hdl/nfir_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module nfir_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic s_axis_tvalid,
    input wire logic s_axis_tready,
    input wire logic m_axis_tvalid,
    input wire logic m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic m_axis_tlast
);
    // A stalled output beat keeps its data.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output beat changed while stalled");
    // A stalled output beat stays valid.
    a_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped");
    // Out of reset the input handshake lines and output valid always carry known levels.
    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid}))
        else $error("handshake line unknown");
    // Once reset has been seen at an edge, the output is idle at the next one.
    a_rst: assert property (@(posedge clk) !rst_n |=> !m_axis_tvalid)
        else $error("output valid in reset");
endmodule

bind normalized_fir_edge_passthrough_top nfir_checker u_checker (
    .clk, .rst_n, .s_axis_tvalid, .s_axis_tready,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tlast
);
`default_nettype wire

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
    import nfir_pkg::*;

    // Register map of the configuration port. The tap count sits at index 0,
    // the seven weights follow it, and anything above the last weight is unused.
    localparam logic [RegIdxBits-1:0] RegCoef0 = 4'd1;
    localparam logic [RegIdxBits-1:0] RegUnused = 4'd8;
    localparam logic [RegIdxBits-1:0] RegTop = 4'd15;
    localparam int  DrainCycles = 120;    // above the longest filtered latency
    localparam longint CycleLimit = 600000;

    typedef struct {
        logic [15:0] value;
        bit          fin;
    } beat_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic [15:0] s_axis_tdata = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tready = 1'b0;
    logic        cfg_we = 1'b0;
    logic [RegIdxBits-1:0] cfg_addr = '0;
    logic [15:0] cfg_wdata = '0;
    wire         s_axis_tready;
    wire         m_axis_tvalid;
    wire  [15:0] m_axis_tdata;
    wire         m_axis_tlast;

    normalized_fir_edge_passthrough_top uut (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    always #6 clk = ~clk;

    // Predictor state: the filter's own registers and sample history.
    logic [2:0]  taps_reg;
    coef_t       weight [MaxTaps];
    sample_t     recent [HistDepth];   // newest first
    int          seen;                 // samples of the open series, saturating
    beat_t       pending_out [$];      // values the block still owes us
    int          errors = 0;
    longint      cycles = 0;
    int          burst_left = 0;

    function automatic sample_t clip16(longint v);
        if (v > 32767) return 16'sd32767;
        if (v < -32768) return -16'sd32768;
        return sample_t'(v);
    endfunction

    // Weighted window sum normalized by the weight sum, ties away from zero.
    // A zero weight sum falls back to a plain Q2.14 scale with floor rounding.
    function automatic sample_t window_average(int hw, sample_t cur);
        longint acc;
        longint wsum;
        longint x;
        longint num;
        longint den;
        longint q;
        acc = 0;
        wsum = 0;
        for (int m = 0; m <= 2 * hw; m++)
        begin
            x = (m == 2 * hw) ? longint'(cur) : longint'(recent[2 * hw - m - 1]);
            acc += longint'(weight[m]) * x;
            wsum += longint'(weight[m]);
        end
        if (wsum == 0)
            return clip16(acc >>> 14);
        num = (acc < 0) ? -acc : acc;
        den = (wsum < 0) ? -wsum : wsum;
        q = (2 * num + den) / (2 * den);
        return clip16(((acc < 0) != (wsum < 0)) ? -q : q);
    endfunction

    // Work out the beats that one accepted sample releases.
    function automatic void predict_outputs(sample_t cur, bit last);
        int t;
        int hw;
        int k;
        int n;
        int r;
        beat_t b;
        t = (taps_reg == 0) ? 1 : int'(taps_reg);
        hw = (t - 1) / 2;
        k = seen;
        n = 0;
        if (k >= hw)
        begin
            if (k >= 2 * hw)
                b.value = window_average(hw, cur);
            else
                b.value = (hw == 0) ? cur : recent[hw - 1];
            b.fin = 1'b0;
            pending_out = {pending_out, b};
            n++;
        end
        if (last)
        begin
            // Flush the tail of the series unfiltered, oldest first.
            r = (k >= hw) ? hw : k + 1;
            for (int d = r - 1; d >= 0; d--)
            begin
                b.value = (d == 0) ? cur : recent[d - 1];
                b.fin = 1'b0;
                pending_out = {pending_out, b};
                n++;
            end
            if (n > 0)
                pending_out[$].fin = 1'b1;
            seen = 0;
        end
        else if (seen < HistDepth)
            seen++;
        for (int j = HistDepth - 1; j > 0; j--)
            recent[j] = recent[j - 1];
        recent[0] = cur;
    endfunction

    // Output side: the ready line follows its own pattern, which switches
    // between always ready, coin flips and a fixed duty cycle.
    int stall_mode = 0;
    int stall_tick = 0;
    always @(negedge clk)
    begin
        stall_tick <= stall_tick + 1;
        if (stall_tick % 97 == 0)
            stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= $urandom_range(0, 1);
            default: m_axis_tready <= (stall_tick % 7) < 4;
        endcase
    end

    // Every beat taken by the receiver is compared with the oldest expectation.
    always @(posedge clk)
    begin
        beat_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_out.size() == 0)
            begin
                $display("%0t: unexpected beat value=%h last=%b", $time,
                         m_axis_tdata, m_axis_tlast);
                errors++;
            end
            else
            begin
                want = pending_out.pop_front();
                if (m_axis_tdata !== want.value)
                begin
                    $display("%0t: value expected %h actual %h", $time,
                             want.value, m_axis_tdata);
                    errors++;
                end
                if (m_axis_tlast !== want.fin)
                begin
                    $display("%0t: last flag expected %b actual %b", $time,
                             want.fin, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Send one sample. The sender runs in bursts; between bursts valid drops
    // for a random number of cycles, and a zero gap keeps valid high.
    task automatic send_sample(input logic [15:0] smp, input bit last);
        int gap;
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= smp;
        s_axis_tlast <= last;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_outputs(sample_t'(smp), last);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 14);
            gap = $urandom_range(0, 4);
            if (gap > 0)
            begin
                @(negedge clk);
                s_axis_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
    endtask

    // Drop valid and wait until every owed beat has arrived, then let the
    // pipeline settle, since a sample may be in flight without a beat owed.
    task automatic drain;
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (pending_out.size() != 0)
            @(negedge clk);
        repeat (DrainCycles) @(negedge clk);
    endtask

    // Register write; only called right after drain, so the block is idle.
    task automatic write_reg(input logic [RegIdxBits-1:0] idx, input logic [15:0] val);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == RegTapCount)
            taps_reg = val[2:0];
        else if (idx < RegUnused)
            weight[idx - RegCoef0] = coef_t'(val);
    endtask

    task automatic load_filter(input int taps, input logic [15:0] w [MaxTaps]);
        drain();
        write_reg(RegTapCount, 16'(taps));
        for (int i = 0; i < MaxTaps; i++)
            write_reg(RegCoef0 + RegIdxBits'(i), w[i]);
    endtask

    // Reset weights with the default three taps: extremes of the sample,
    // a one-sample series and a short series that passes through whole.
    task automatic test_defaults;
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h7fff, 1'b0);
        send_sample(16'h8000, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h1234, 1'b1);
        send_sample(16'hffff, 1'b0);
        send_sample(16'h0000, 1'b1);
    endtask

    // Seven taps with extreme weights, then a zero weight sum, an even and a
    // zero tap count, and a write to an index past the last weight.
    task automatic test_weights;
        logic [15:0] w [MaxTaps];
        w = '{16'h7fff, 16'h8000, 16'h7fff, 16'h7fff, 16'h8000, 16'h0001, 16'hffff};
        load_filter(7, w);
        for (int i = 0; i < 8; i++)
            send_sample(i[0] ? 16'h8000 : 16'h7fff, i == 7);
        w = '{16'h4000, 16'hc000, 16'h7fff, 16'h8001, 16'h0000, 16'h0000, 16'h0000};
        load_filter(5, w);
        for (int i = 0; i < 6; i++)
            send_sample(i[0] ? 16'h8000 : 16'h7fff, i == 5);
        drain();
        write_reg(RegTapCount, 16'd4);
        write_reg(RegUnused, 16'h5a5a);
        write_reg(RegTop, 16'ha5a5);
        send_sample(16'h0101, 1'b0);
        send_sample(16'hfefe, 1'b1);
        drain();
        write_reg(RegTapCount, 16'd0);
        send_sample(16'h8000, 1'b1);
    endtask

    // Random series, mostly long enough to reach the filtered middle, under
    // a new random configuration every few series. Once the tap count is
    // changed while a series is still open.
    task automatic test_random_series;
        logic [15:0] w [MaxTaps];
        int len;
        int items;
        logic [15:0] smp;
        items = 0;
        for (int phase = 0; items < 150; phase++)
        begin
            for (int i = 0; i < MaxTaps; i++)
            begin
                case ($urandom_range(0, 5))
                    0: w[i] = 16'h4000;
                    1: w[i] = $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
                    2: w[i] = 16'h0000;
                    default: w[i] = 16'($urandom);
                endcase
            end
            load_filter($urandom_range(0, 7), w);
            for (int s = 0; s < 3; s++)
            begin
                len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 4)
                                                  : $urandom_range(5, 16);
                for (int i = 0; i < len; i++)
                begin
                    smp = ($urandom_range(0, 9) == 0)
                        ? ($urandom_range(0, 1) ? 16'h7fff : 16'h8000) : 16'($urandom);
                    send_sample(smp, i == len - 1);
                    items++;
                    if (phase == 1 && s == 0 && i == 2)
                    begin
                        drain();
                        write_reg(RegTapCount, 16'($urandom_range(1, 7)));
                    end
                end
            end
        end
    endtask

    initial
    begin
        taps_reg = 3'd3;
        weight = '{16'sd16384, 16'sd16384, 16'sd16384, 16'sd0, 16'sd0, 16'sd0, 16'sd0};
        recent = '{default: '0};
        seen = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        test_defaults();
        test_weights();
        test_random_series();
        drain();
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule
